// File: sv/fqp_pkg.sv
`default_nettype none

package fqp_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_SEEK,
		PH_NAME,
		PH_SEQ,
		PH_COMMENT,
		PH_QUAL
	} fqp_phase_t;

	// result kinds
	localparam logic [2:0] KIND_NAME_BYTE = 3'd0;
	localparam logic [2:0] KIND_NAME_END  = 3'd1;
	localparam logic [2:0] KIND_BASE      = 3'd2;
	localparam logic [2:0] KIND_QUAL      = 3'd3;
	localparam logic [2:0] KIND_REC_END   = 3'd4;
	localparam logic [2:0] KIND_NO_REC    = 3'd5;
	localparam logic [2:0] KIND_ERROR     = 3'd6;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_BAD_BASE   = 2'd1;
	localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
	localparam logic [1:0] ERR_MISMATCH   = 2'd3;

	// characters
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_C  = 8'h43;
	localparam logic [7:0] CH_UP_G  = 8'h47;
	localparam logic [7:0] CH_UP_T  = 8'h54;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_MASK = 8'hDF;
	localparam logic [7:0] QUAL_MIN = 8'd33;
	localparam logic [7:0] QUAL_MAX = 8'd127;

	// most results one input byte can cause
	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} fqp_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic [15:0] base_count;
		logic [15:0] qual_count;
		logic [1:0]  error_code;
		logic        last;
	} fqp_result_t;

	// results of one input byte, packed from slot 0
	typedef struct packed {
		logic [1:0]                       count;
		fqp_result_t [MAX_RESULTS-1:0]    res;
	} fqp_batch_t;

	function automatic logic is_white(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	// 2-bit base code of a letter of either case, 4 for other letters
	function automatic logic [7:0] base_code(input logic [7:0] c);
		logic [7:0] up;
		logic [7:0] code;
		up = c & CASE_MASK;
		unique case (up)
			CH_UP_A: code = 8'd0;
			CH_UP_C: code = 8'd1;
			CH_UP_G: code = 8'd2;
			CH_UP_T: code = 8'd3;
			default: code = 8'd4;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// File: sv/fastq_record_parser.sv
`default_nettype none

// Streaming FASTQ parser: one text byte per transaction on the item channel,
// results one per transaction on the result channel. Each byte is parsed in
// the cycle it is accepted, so the input takes one byte per clock when not
// stalled. A byte causes zero to three results, which wait in a four-entry
// result queue; the input stalls while two or more results are waiting, so
// a name end releasing two held name bytes gives three results. Counts
// saturate at 2**COUNT_WIDTH-1 and are reported in their low 16 bits.

module fastq_record_parser import fqp_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire fqp_item_t   item,
	output logic             result_valid,
	input  wire logic        result_ready,
	output fqp_result_t      result
);

	logic       accept;
	fqp_batch_t batch;

	assign accept = item_valid && item_ready;

	// parse the accepted byte
	fqp_parse #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.batch  (batch)
	);

	// queue results toward the output
	fqp_rqueue u_rqueue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.batch     (batch),
		.space     (item_ready),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result)
	);

	// end of stream always gives a result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.stream_end |=> result_valid)
		else $error("end of stream transaction produced no result");

	// input is held back only while results wait
	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("input stalled with an empty result queue");

	// a clean record end has matching counts
	a_rec_end_counts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_REC_END && result.error_code == ERR_NONE
		|-> result.base_count == result.qual_count)
		else $error("record end without error carries differing counts");

endmodule

`default_nettype wire

// File: sv/fqp_parse.sv
`default_nettype none

module fqp_parse import fqp_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire fqp_item_t  item,
	output fqp_batch_t      batch
);

	fqp_phase_t             phase_q, phase_d;
	logic [7:0]             held0_q, held0_d;
	logic [7:0]             held1_q, held1_d;
	logic [1:0]             held_cnt_q, held_cnt_d;
	logic                   name_cut_q, name_cut_d;
	logic [1:0]             name_len_q, name_len_d;
	logic [COUNT_WIDTH-1:0] bases_q, bases_d;
	logic [COUNT_WIDTH-1:0] quals_q, quals_d;

	fqp_result_t [MAX_RESULTS-1:0] res;
	logic [1:0]                    n;
	logic                          drop;
	logic [7:0]                    c;

	function automatic fqp_result_t mk(input logic [2:0] kind, input logic [7:0] value,
		input logic [15:0] bc, input logic [15:0] qc, input logic [1:0] err);
		fqp_result_t r;
		r.kind       = kind;
		r.value      = value;
		r.base_count = bc;
		r.qual_count = qc;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

	// next state and results for the presented byte
	always_comb begin
		phase_d    = phase_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		held_cnt_d = held_cnt_q;
		name_cut_d = name_cut_q;
		name_len_d = name_len_q;
		bases_d    = bases_q;
		quals_d    = quals_q;
		res        = '0;
		n          = 2'd0;
		c          = item.data_byte;
		drop       = held_cnt_q == 2'd2 && name_len_q == 2'd3 && held0_q == CH_SLASH &&
			(held1_q == CH_ONE || held1_q == CH_TWO);

		if (item.stream_end) begin
			unique case (phase_q)
				PH_SEEK: res[0] = mk(KIND_NO_REC, 8'd0, 16'd0, 16'd0, ERR_NONE);
				PH_QUAL: res[0] = mk(KIND_REC_END, 8'd0, 16'(bases_q), 16'(quals_q),
					(bases_q != quals_q) ? ERR_MISMATCH : ERR_NONE);
				default: res[0] = mk(KIND_ERROR, 8'd0, 16'd0, 16'd0, ERR_INCOMPLETE);
			endcase
			n = 2'd1;
			phase_d = PH_SEEK;
		end else begin
			unique case (phase_q)
				PH_SEEK: begin
					if (c == CH_AT) begin
						phase_d = PH_NAME;
					end
				end
				PH_NAME: begin
					if (name_cut_q) begin
						if (c == CH_LF) begin
							phase_d = PH_SEQ;
						end
					end else if (is_white(c)) begin
						// flush held bytes unless they are a /1 or /2 suffix
						if (!drop && held_cnt_q != 2'd0) begin
							res[n] = mk(KIND_NAME_BYTE, held0_q, 16'd0, 16'd0, ERR_NONE);
							n = n + 2'd1;
						end
						if (!drop && held_cnt_q == 2'd2) begin
							res[n] = mk(KIND_NAME_BYTE, held1_q, 16'd0, 16'd0, ERR_NONE);
							n = n + 2'd1;
						end
						res[n] = mk(KIND_NAME_END, 8'd0, 16'd0, 16'd0, ERR_NONE);
						n = n + 2'd1;
						held_cnt_d = 2'd0;
						if (c == CH_LF) begin
							phase_d = PH_SEQ;
						end else begin
							name_cut_d = 1'b1;
						end
					end else begin
						// two-byte hold in front of the name output
						if (held_cnt_q == 2'd2) begin
							res[0] = mk(KIND_NAME_BYTE, held0_q, 16'd0, 16'd0, ERR_NONE);
							n = 2'd1;
							held0_d = held1_q;
							held1_d = c;
						end else if (held_cnt_q == 2'd1) begin
							held1_d = c;
							held_cnt_d = 2'd2;
						end else begin
							held0_d = c;
							held_cnt_d = 2'd1;
						end
						if (name_len_q != 2'd3) begin
							name_len_d = name_len_q + 2'd1;
						end
					end
				end
				PH_SEQ: begin
					if (c == CH_CR || c == CH_LF) begin
						// line breaks inside the sequence are skipped
					end else if (c == CH_PLUS) begin
						phase_d = PH_COMMENT;
					end else if ((c >= CH_UP_A && c <= CH_UP_Z) ||
						(c >= CH_LO_A && c <= CH_LO_Z)) begin
						res[0] = mk(KIND_BASE, base_code(c), 16'd0, 16'd0, ERR_NONE);
						n = 2'd1;
						if (bases_q != '1) begin
							bases_d = bases_q + COUNT_WIDTH'(1);
						end
					end else begin
						res[0] = mk(KIND_ERROR, c, 16'd0, 16'd0, ERR_BAD_BASE);
						n = 2'd1;
					end
				end
				PH_COMMENT: begin
					if (c == CH_LF) begin
						phase_d = PH_QUAL;
					end
				end
				PH_QUAL: begin
					if (c == CH_LF) begin
						res[0] = mk(KIND_REC_END, 8'd0, 16'(bases_q), 16'(quals_q),
							(bases_q != quals_q) ? ERR_MISMATCH : ERR_NONE);
						n = 2'd1;
						phase_d = PH_SEEK;
					end else if (c >= QUAL_MIN && c <= QUAL_MAX) begin
						res[0] = mk(KIND_QUAL, c, 16'd0, 16'd0, ERR_NONE);
						n = 2'd1;
						if (quals_q != '1) begin
							quals_d = quals_q + COUNT_WIDTH'(1);
						end
					end
				end
				default: begin
					phase_d = PH_SEEK;
				end
			endcase
		end

		// a new record starts clean whenever we enter or return to seek/name
		if (phase_d == PH_SEEK || (phase_q == PH_SEEK && phase_d == PH_NAME)) begin
			held0_d    = 8'd0;
			held1_d    = 8'd0;
			held_cnt_d = 2'd0;
			name_cut_d = 1'b0;
			name_len_d = 2'd0;
			bases_d    = '0;
			quals_d    = '0;
		end

		// mark the final result of this byte
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
		end

		batch.count = n;
		batch.res   = res;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEEK;
			held0_q    <= 8'd0;
			held1_q    <= 8'd0;
			held_cnt_q <= 2'd0;
			name_cut_q <= 1'b0;
			name_len_q <= 2'd0;
			bases_q    <= '0;
			quals_q    <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			held0_q    <= held0_d;
			held1_q    <= held1_d;
			held_cnt_q <= held_cnt_d;
			name_cut_q <= name_cut_d;
			name_len_q <= name_len_d;
			bases_q    <= bases_d;
			quals_q    <= quals_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/fqp_rqueue.sv
`default_nettype none

module fqp_rqueue import fqp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire fqp_batch_t  batch,
	output logic             space,
	output logic             out_valid,
	input  wire logic        out_ready,
	output fqp_result_t      out_data
);

	fqp_result_t ent_q [4];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  cnt_q;
	logic        pop;
	logic [2:0]  add;

	// room for a full batch while at most one result waits
	assign space     = cnt_q <= 3'd1;
	assign out_valid = cnt_q != 3'd0;
	assign out_data  = ent_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign add       = push ? {1'b0, batch.count} : 3'd0;

	// result storage
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				if (2'(i) < batch.count) begin
					ent_q[wr_q + 2'(i)] <= batch.res[i];
				end
			end
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + add[1:0];
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + add - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_fastq_record_parser.sv
`timescale 1ns / 1ps

module tb_fastq_record_parser import fqp_pkg::*; ();

	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// one byte of text plus an optional hand-written result
	typedef struct {
		fqp_item_t   it;
		bit          typed;
		fqp_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	fqp_item_t   item;
	logic        result_valid;
	logic        result_ready;
	fqp_result_t result;

	stim_row_t   directed_rows[$];
	stim_row_t   pending_rows[$];
	fqp_result_t due_results[$];
	fqp_result_t byte_results[$];
	int          errors;
	int          idle_cycles;
	int          burst_left;
	int          text_items;
	bit          hold_off_req;

	// parser state as seen by the predictor
	fqp_phase_t  phase;
	logic [7:0]  held [2];
	int          held_n;
	bit          name_done;
	logic [15:0] name_count;
	logic [15:0] base_total;
	logic [15:0] qual_total;

	fastq_record_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
			c == CH_CR;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
	endfunction

	function automatic logic [7:0] letter_code(input logic [7:0] c);
		logic [7:0] up;
		up = (c >= CH_LO_A) ? c - CASE_BIT : c;
		case (up)
			CH_UP_A: return 8'd0;
			CH_UP_C: return 8'd1;
			CH_UP_G: return 8'd2;
			CH_UP_T: return 8'd3;
			default: return 8'd4;
		endcase
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic void add_result(input logic [2:0] kind, input logic [7:0] value,
			input logic [15:0] bc, input logic [15:0] qc, input logic [1:0] err);
		fqp_result_t r;
		r = '{kind: kind, value: value, base_count: bc, qual_count: qc, error_code: err,
			last: 1'b0};
		byte_results.push_back(r);
	endfunction

	function automatic void clear_record();
		held[0] = 8'h00;
		held[1] = 8'h00;
		held_n = 0;
		name_done = 1'b0;
		name_count = '0;
		base_total = '0;
		qual_total = '0;
	endfunction

	function automatic logic [1:0] length_check();
		return (base_total != qual_total) ? ERR_MISMATCH : ERR_NONE;
	endfunction

	// results caused by one accepted text byte, left in byte_results
	function automatic void parse_byte(input fqp_item_t it);
		logic [7:0] c;
		bit drop;
		int i;
		c = it.data_byte;
		byte_results.delete();
		if (it.stream_end) begin
			case (phase)
				PH_SEEK: add_result(KIND_NO_REC, 8'h00, 16'd0, 16'd0, ERR_NONE);
				PH_QUAL: add_result(KIND_REC_END, 8'h00, base_total, qual_total, length_check());
				default: add_result(KIND_ERROR, 8'h00, 16'd0, 16'd0, ERR_INCOMPLETE);
			endcase
			clear_record();
			phase = PH_SEEK;
		end else begin
			case (phase)
				PH_SEEK: begin
					if (c == CH_AT) begin
						clear_record();
						phase = PH_NAME;
					end
				end
				PH_NAME: begin
					if (name_done) begin
						if (c == CH_LF)
							phase = PH_SEQ;
					end else if (is_space(c)) begin
						// a trailing /1 or /2 on a name of three or more bytes is dropped
						drop = held_n == 2 && name_count > 16'd2 && held[0] == CH_SLASH &&
							(held[1] == CH_ONE || held[1] == CH_TWO);
						if (!drop)
							for (i = 0; i < held_n; i++)
								add_result(KIND_NAME_BYTE, held[1'(i)], 16'd0, 16'd0,
									ERR_NONE);
						add_result(KIND_NAME_END, 8'h00, 16'd0, 16'd0, ERR_NONE);
						held_n = 0;
						if (c == CH_LF)
							phase = PH_SEQ;
						else
							name_done = 1'b1;
					end else begin
						if (held_n == 2) begin
							add_result(KIND_NAME_BYTE, held[0], 16'd0, 16'd0, ERR_NONE);
							held[0] = held[1];
							held[1] = c;
						end else begin
							held[1'(held_n)] = c;
							held_n++;
						end
						name_count = sat_inc(name_count);
					end
				end
				PH_SEQ: begin
					if (c == CH_PLUS) begin
						phase = PH_COMMENT;
					end else if (is_letter(c)) begin
						add_result(KIND_BASE, letter_code(c), 16'd0, 16'd0, ERR_NONE);
						base_total = sat_inc(base_total);
					end else if (c != CH_CR && c != CH_LF) begin
						add_result(KIND_ERROR, c, 16'd0, 16'd0, ERR_BAD_BASE);
					end
				end
				PH_COMMENT: begin
					if (c == CH_LF)
						phase = PH_QUAL;
				end
				PH_QUAL: begin
					if (c == CH_LF) begin
						add_result(KIND_REC_END, 8'h00, base_total, qual_total, length_check());
						clear_record();
						phase = PH_SEEK;
					end else if (c >= QUAL_MIN && c <= QUAL_MAX) begin
						add_result(KIND_QUAL, c, 16'd0, 16'd0, ERR_NONE);
						qual_total = sat_inc(qual_total);
					end
				end
				default: begin
					clear_record();
					phase = PH_SEEK;
				end
			endcase
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
	endfunction

	function automatic stim_row_t feed(input logic [7:0] c, input logic eos);
		stim_row_t r;
		r.it = '{data_byte: c, stream_end: eos};
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// row whose single result is written out by hand
	function automatic stim_row_t feed_want(input logic [7:0] c, input logic eos,
			input logic [2:0] kind, input logic [7:0] value, input logic [15:0] bc,
			input logic [15:0] qc, input logic [1:0] err);
		stim_row_t r;
		r = feed(c, eos);
		r.typed = 1'b1;
		r.want = '{kind: kind, value: value, base_count: bc, qual_count: qc, error_code: err,
			last: 1'b1};
		return r;
	endfunction

	function automatic bit field_differs(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got === want)
			return 1'b0;
		$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		return 1'b1;
	endfunction

	// offer one byte, hold it until accepted, then maybe pause the burst
	task automatic send_item(input stim_row_t row);
		pending_rows.push_back(row);
		item_valid <= 1'b1;
		item <= row.it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// one random record, sometimes with stray bytes, a bad base or a cut-off end
	task automatic send_record();
		stim_row_t text[$];
		logic [7:0] c;
		int n_letters;
		int n_quals;
		int cut_at;
		n_letters = 0;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				c = 8'($urandom_range(0, 255));
				while (c == CH_AT)
					c = 8'($urandom_range(0, 255));
				send_item(feed(c, 1'b0));
			end
		end
		if ($urandom_range(0, 24) == 0) begin
			send_item(feed(8'($urandom_range(0, 255)), 1'b1));
			text_items++;
			return;
		end

		// header: name, optional read suffix, rest of line
		text.push_back(feed(CH_AT, 1'b0));
		repeat ($urandom_range(1, 8)) begin
			c = 8'($urandom_range(0, 255));
			while (is_space(c))
				c = 8'($urandom_range(0, 255));
			text.push_back(feed(c, 1'b0));
		end
		if ($urandom_range(0, 2) == 0) begin
			text.push_back(feed(CH_SLASH, 1'b0));
			text.push_back(feed($urandom_range(0, 1) ? CH_ONE : CH_TWO, 1'b0));
		end
		case ($urandom_range(0, 5))
			0: c = CH_SP;
			1: c = CH_TAB;
			2: c = CH_VT;
			3: c = CH_FF;
			4: c = CH_CR;
			default: c = CH_LF;
		endcase
		text.push_back(feed(c, 1'b0));
		if (c != CH_LF) begin
			repeat ($urandom_range(0, 4)) begin
				c = 8'($urandom_range(0, 255));
				while (c == CH_LF)
					c = 8'($urandom_range(0, 255));
				text.push_back(feed(c, 1'b0));
			end
			text.push_back(feed(CH_LF, 1'b0));
		end

		// sequence line
		repeat ($urandom_range(0, 12)) begin
			case ($urandom_range(0, 15))
				0: c = $urandom_range(0, 1) ? CH_CR : CH_LF;
				1: begin
					c = 8'($urandom_range(0, 255));
					while (is_letter(c) || c == CH_PLUS || c == CH_CR || c == CH_LF)
						c = 8'($urandom_range(0, 255));
				end
				default: begin
					case ($urandom_range(0, 4))
						0: c = CH_UP_A;
						1: c = CH_UP_C;
						2: c = CH_UP_G;
						3: c = CH_UP_T;
						default: c = 8'($urandom_range(CH_UP_A, CH_UP_Z));
					endcase
					if ($urandom_range(0, 2) == 0)
						c = c | CASE_BIT;
					n_letters++;
				end
			endcase
			text.push_back(feed(c, 1'b0));
		end

		// separator and comment line
		text.push_back(feed(CH_PLUS, 1'b0));
		repeat ($urandom_range(0, 3)) begin
			c = 8'($urandom_range(0, 255));
			while (c == CH_LF)
				c = 8'($urandom_range(0, 255));
			text.push_back(feed(c, 1'b0));
		end
		text.push_back(feed(CH_LF, 1'b0));

		// quality line, mostly matching the base count
		n_quals = ($urandom_range(0, 4) != 0) ? n_letters : $urandom_range(0, 12);
		repeat (n_quals) begin
			if ($urandom_range(0, 7) == 0) begin
				c = 8'($urandom_range(0, 255));
				while ((c >= QUAL_MIN && c <= QUAL_MAX) || c == CH_LF)
					c = 8'($urandom_range(0, 255));
				text.push_back(feed(c, 1'b0));
			end
			text.push_back(feed(8'($urandom_range(QUAL_MIN, QUAL_MAX)), 1'b0));
		end
		if ($urandom_range(0, 7) == 0)
			text.push_back(feed(8'($urandom_range(0, 255)), 1'b1));
		else
			text.push_back(feed(CH_LF, 1'b0));

		// broken record: stream ends somewhere inside it
		if ($urandom_range(0, 7) == 0) begin
			cut_at = $urandom_range(1, text.size() - 1);
			while (text.size() > cut_at)
				void'(text.pop_back());
			text.push_back(feed(8'($urandom_range(0, 255)), 1'b1));
		end

		foreach (text[i])
			send_item(text[i]);
		text_items += text.size();
	endtask

	// result side: stall pattern that changes every so often, plus one long hold-off
	initial begin
		int unsigned cyc;
		int unsigned mode;
		bit held_off;
		cyc = 0;
		mode = 0;
		held_off = 1'b0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_off_req && !held_off) begin
				held_off = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			case (mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				2: result_ready <= (cyc % 4 == 0);
				default: result_ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// predict on every byte transaction, check every result transaction
	always @(posedge clk) begin
		stim_row_t row;
		fqp_result_t want;
		bit moved;
		bit bad;
		if (arst_n) begin
			moved = 1'b0;
			if (item_valid && item_ready) begin
				moved = 1'b1;
				row = pending_rows.pop_front();
				parse_byte(item);
				if (row.typed)
					due_results.push_back(row.want);
				else
					foreach (byte_results[i])
						due_results.push_back(byte_results[i]);
			end
			if (result_valid && result_ready) begin
				moved = 1'b1;
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: expected no result, got kind %0d value %0d", $time,
						result.kind, result.value);
				end else begin
					want = due_results.pop_front();
					bad = field_differs("kind", 16'(want.kind), 16'(result.kind)) |
						field_differs("value", 16'(want.value), 16'(result.value)) |
						field_differs("base_count", want.base_count, result.base_count) |
						field_differs("qual_count", want.qual_count, result.qual_count) |
						field_differs("error_code", 16'(want.error_code),
							16'(result.error_code)) |
						field_differs("last", 16'(want.last), 16'(result.last));
					if (bad)
						errors++;
				end
			end
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
					$display("FAILED: results differ");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		hold_off_req = 1'b0;
		errors = 0;
		idle_cycles = 0;
		text_items = 0;
		burst_left = $urandom_range(1, 40);
		phase = PH_SEEK;
		clear_record();

		// directed text: end with no record, a name with /1 dropped, every base
		// letter kind, bad bases, quality bytes at and past the limits, mismatch at
		// end of stream, then a record cut off in its name
		directed_rows.push_back(feed_want(8'h00, 1'b1, KIND_NO_REC, 8'h00, 16'd0, 16'd0,
			ERR_NONE));
		directed_rows.push_back(feed("x", 1'b0));
		directed_rows.push_back(feed(CH_AT, 1'b0));
		directed_rows.push_back(feed("r", 1'b0));
		directed_rows.push_back(feed(CH_SLASH, 1'b0));
		directed_rows.push_back(feed(CH_ONE, 1'b0));
		directed_rows.push_back(feed_want(CH_SP, 1'b0, KIND_NAME_END, 8'h00, 16'd0, 16'd0,
			ERR_NONE));
		directed_rows.push_back(feed("z", 1'b0));
		directed_rows.push_back(feed(CH_LF, 1'b0));
		directed_rows.push_back(feed(CH_UP_A, 1'b0));
		directed_rows.push_back(feed("c", 1'b0));
		directed_rows.push_back(feed(CH_UP_G, 1'b0));
		directed_rows.push_back(feed("t", 1'b0));
		directed_rows.push_back(feed("N", 1'b0));
		directed_rows.push_back(feed(CH_CR, 1'b0));
		directed_rows.push_back(feed_want("!", 1'b0, KIND_ERROR, "!", 16'd0, 16'd0,
			ERR_BAD_BASE));
		directed_rows.push_back(feed_want(8'hFF, 1'b0, KIND_ERROR, 8'hFF, 16'd0, 16'd0,
			ERR_BAD_BASE));
		directed_rows.push_back(feed(CH_PLUS, 1'b0));
		directed_rows.push_back(feed("q", 1'b0));
		directed_rows.push_back(feed(CH_LF, 1'b0));
		directed_rows.push_back(feed(QUAL_MIN, 1'b0));
		directed_rows.push_back(feed(QUAL_MAX, 1'b0));
		directed_rows.push_back(feed(8'h80, 1'b0));
		directed_rows.push_back(feed(8'h00, 1'b0));
		directed_rows.push_back(feed_want(8'hFF, 1'b1, KIND_REC_END, 8'h00, 16'd5, 16'd2,
			ERR_MISMATCH));
		directed_rows.push_back(feed(CH_AT, 1'b0));
		directed_rows.push_back(feed_want(8'h00, 1'b1, KIND_ERROR, 8'h00, 16'd0, 16'd0,
			ERR_INCOMPLETE));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// random records; the result side holds off once early on
		hold_off_req = 1'b1;
		while (text_items < RANDOM_ITEMS)
			send_record();
		item_valid <= 1'b0;

		// drain, then let any late extra result show up
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
